// ===== rtl/rpd_pkg.sv =====
// Shared types and constants for the read priority dispatch arbiter.
// Holds the request and response beat layouts, status codes and reset values.
// No dependencies.
package rpd_pkg;

   localparam int unsigned TAG_W   = 16;
   localparam int unsigned LIMIT_W = 8;
   localparam int unsigned CNT_W   = 9;

   localparam logic [LIMIT_W-1:0] STARVE_LIMIT_RESET = 8'd4;

   localparam logic ACT_ADD      = 1'b0;
   localparam logic ACT_DISPATCH = 1'b1;

   localparam logic CLASS_FAVORED   = 1'b0;
   localparam logic CLASS_STARVABLE = 1'b1;

   typedef enum logic [1:0] {
      ST_ADDED = 2'd0,
      ST_FULL  = 2'd1,
      ST_GRANT = 2'd2,
      ST_NONE  = 2'd3
   } status_type;

   typedef struct packed {
      logic             action;
      logic [TAG_W-1:0] req_tag;
      logic             req_class;
   } req_beat_type;

   typedef struct packed {
      status_type       status;
      logic [TAG_W-1:0] grant_tag;
      logic             grant_class;
   } rsp_beat_type;

   typedef struct packed {
      logic fav_pop;
      logic stv_pop;
   } arb_grant_type;

endpackage

// ===== rtl/rpd_tag_queue.sv =====
// One tag FIFO: a synchronous memory with a registered read port
// and head, tail and fill count registers. Depends on rpd_pkg.
module rpd_tag_queue #(
   parameter int unsigned QUEUE_DEPTH = 16
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      push,
   input  logic [rpd_pkg::TAG_W-1:0] push_tag,
   input  logic                      pop,
   output logic [rpd_pkg::TAG_W-1:0] pop_tag,
   output logic                      full,
   output logic                      empty
);
   import rpd_pkg::*;

   localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int unsigned FILL_W = $clog2(QUEUE_DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(QUEUE_DEPTH - 1);
   localparam logic [FILL_W-1:0] FULL_FILL = FILL_W'(QUEUE_DEPTH);

   logic [TAG_W-1:0]  mem [QUEUE_DEPTH];
   logic [TAG_W-1:0]  rd_data_ff;
   logic [PTR_W-1:0]  head_ff, head_in;
   logic [PTR_W-1:0]  tail_ff, tail_in;
   logic [FILL_W-1:0] fill_ff, fill_in;

   assign full    = (fill_ff == FULL_FILL);
   assign empty   = (fill_ff == '0);
   assign pop_tag = rd_data_ff;

   always_comb begin
      head_in = head_ff;
      tail_in = tail_ff;
      fill_in = fill_ff;
      if (push) begin
         tail_in = (tail_ff == LAST_PTR) ? '0 : tail_ff + PTR_W'(1);
         fill_in = fill_in + FILL_W'(1);
      end
      if (pop) begin
         head_in = (head_ff == LAST_PTR) ? '0 : head_ff + PTR_W'(1);
         fill_in = fill_in - FILL_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff <= '0;
         tail_ff <= '0;
         fill_ff <= '0;
      end else begin
         head_ff <= head_in;
         tail_ff <= tail_in;
         fill_ff <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem[tail_ff] <= push_tag;
      end
      if (pop) begin
         rd_data_ff <= mem[head_ff];
      end
   end

endmodule

// ===== rtl/rpd_arbiter.sv =====
// Dispatch arbiter: the starvation limit register, the starvation counter
// and the choice of which queue head to pop. Depends on rpd_pkg.
module rpd_arbiter (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        dispatch,
   input  logic                        fav_empty,
   input  logic                        stv_empty,
   input  logic                        csr_we,
   input  logic [rpd_pkg::LIMIT_W-1:0] csr_wdata,
   output rpd_pkg::arb_grant_type      grant
);
   import rpd_pkg::*;

   logic [LIMIT_W-1:0] limit_ff;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               starved;

   assign starved = count_ff > {1'b0, limit_ff};

   always_comb begin
      grant    = '0;
      count_in = count_ff;
      if (dispatch) begin
         if (!starved && !fav_empty) begin
            grant.fav_pop = 1'b1;
            count_in      = count_ff + CNT_W'(1);
         end else begin
            grant.stv_pop = !stv_empty;
            count_in      = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff <= STARVE_LIMIT_RESET;
         count_ff <= '0;
      end else begin
         if (csr_we) begin
            limit_ff <= csr_wdata;
         end
         count_ff <= count_in;
      end
   end

endmodule

// ===== rtl/read_priority_dispatch_arbiter_unit.sv =====
// Top level of the read priority dispatch arbiter: two tag queues and the
// dispatch arbiter. Depends on rpd_pkg, rpd_tag_queue and rpd_arbiter.
//
//   Channel   Ports                     Direction  Handshake
//   request   start, busy, req_data     in         beat taken when start && !busy
//   response  rsp_valid, rsp_data       out        one-cycle strobe, no back-pressure
//   config    csr_we, csr_wdata         in         written when csr_we is high
//
// In the accept cycle a beat updates the queue pointers and a dispatch starts
// the head read; the queue memory returns the tag in the next cycle, when the
// response is strobed. busy is high during that cycle.
// Reset empties both queues, clears the counter and loads the limit with 4.
// The receiver cannot stall the response.
module read_priority_dispatch_arbiter_unit #(
   parameter int unsigned QUEUE_DEPTH = 16
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   output logic                        busy,
   input  rpd_pkg::req_beat_type       req_data,
   output logic                        rsp_valid,
   output rpd_pkg::rsp_beat_type       rsp_data,
   input  logic                        csr_we,
   input  logic [rpd_pkg::LIMIT_W-1:0] csr_wdata
);
   import rpd_pkg::*;

   logic             accept, is_add;
   logic             fav_push, stv_push;
   logic             fav_full, fav_empty, stv_full, stv_empty;
   logic [TAG_W-1:0] fav_tag, stv_tag;
   arb_grant_type    grant;
   status_type       status_in, status_ff;
   logic             class_in, class_ff;
   logic             pend_ff;

   assign busy     = pend_ff;
   assign accept   = start && !busy;
   assign is_add   = (req_data.action == ACT_ADD);
   assign fav_push = accept && is_add && (req_data.req_class == CLASS_FAVORED) && !fav_full;
   assign stv_push = accept && is_add && (req_data.req_class == CLASS_STARVABLE) && !stv_full;

   rpd_tag_queue #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_fav_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (fav_push),
      .push_tag (req_data.req_tag),
      .pop      (grant.fav_pop),
      .pop_tag  (fav_tag),
      .full     (fav_full),
      .empty    (fav_empty)
   );

   rpd_tag_queue #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_stv_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (stv_push),
      .push_tag (req_data.req_tag),
      .pop      (grant.stv_pop),
      .pop_tag  (stv_tag),
      .full     (stv_full),
      .empty    (stv_empty)
   );

   rpd_arbiter u_arbiter (
      .clock     (clock),
      .reset     (reset),
      .dispatch  (accept && !is_add),
      .fav_empty (fav_empty),
      .stv_empty (stv_empty),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata),
      .grant     (grant)
   );

   always_comb begin
      class_in = CLASS_FAVORED;
      if (is_add) begin
         status_in = (fav_push || stv_push) ? ST_ADDED : ST_FULL;
      end else if (grant.fav_pop || grant.stv_pop) begin
         status_in = ST_GRANT;
         class_in  = grant.stv_pop ? CLASS_STARVABLE : CLASS_FAVORED;
      end else begin
         status_in = ST_NONE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff <= 1'b0;
      end else begin
         pend_ff <= accept;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         status_ff <= status_in;
         class_ff  <= class_in;
      end
   end

   always_comb begin
      rsp_valid            = pend_ff;
      rsp_data.status      = status_ff;
      rsp_data.grant_class = 1'b0;
      rsp_data.grant_tag   = '0;
      if (status_ff == ST_GRANT) begin
         rsp_data.grant_class = class_ff;
         rsp_data.grant_tag   = (class_ff == CLASS_STARVABLE) ? stv_tag : fav_tag;
      end
   end

endmodule

// ===== tb/read_priority_dispatch_arbiter_unit_test.sv =====
// Self-checking testbench for read_priority_dispatch_arbiter_unit: directed and random
// add and dispatch beats, checked against an in-file queue and starvation model.
// Depends on rpd_pkg and the read_priority_dispatch_arbiter_unit RTL.
module read_priority_dispatch_arbiter_unit_test;
   timeunit 1ns;
   timeprecision 1ps;

   import rpd_pkg::*;

   localparam int unsigned DEPTH = 16;

   logic               clock;
   logic               reset;
   logic               start;
   logic               busy;
   req_beat_type       req_data;
   logic               rsp_valid;
   rsp_beat_type       rsp_data;
   logic               csr_we;
   logic [LIMIT_W-1:0] csr_wdata;

   rsp_beat_type       awaited_rsp_q[$];
   logic [TAG_W-1:0]   fav_tags[$];
   logic [TAG_W-1:0]   stv_tags[$];
   logic [CNT_W-1:0]   starve_cnt;
   logic [LIMIT_W-1:0] starve_lim;

   int idle_pct;
   int errors;
   int n_beats;
   int n_added;
   int n_full;
   int n_fav_grants;
   int n_stv_grants;
   int n_none;
   int n_forced_stv;
   int n_starved_empty;

   read_priority_dispatch_arbiter_unit #(
      .QUEUE_DEPTH(DEPTH)
   ) u_dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #2_000_000;
      $display("== FAIL ==");
      $finish;
   end

   task automatic report_mismatch(input string msg);
      errors++;
      if (errors <= 40) begin
         $display("[%0t] mismatch: %s", $time, msg);
      end
   endtask

   function automatic rsp_beat_type arbiter_response(input req_beat_type beat);
      rsp_beat_type rsp;
      int           depth_now;
      rsp = '0;
      n_beats++;
      if (beat.action == ACT_ADD) begin
         depth_now = (beat.req_class == CLASS_STARVABLE) ? stv_tags.size() : fav_tags.size();
         if (depth_now >= DEPTH) begin
            rsp.status = ST_FULL;
            n_full++;
         end else begin
            if (beat.req_class == CLASS_STARVABLE) begin
               stv_tags.push_back(beat.req_tag);
            end else begin
               fav_tags.push_back(beat.req_tag);
            end
            rsp.status = ST_ADDED;
            n_added++;
         end
      end else if (starve_cnt <= starve_lim && fav_tags.size() != 0) begin
         starve_cnt       = starve_cnt + 1'b1;
         rsp.status       = ST_GRANT;
         rsp.grant_tag    = fav_tags.pop_front();
         rsp.grant_class  = CLASS_FAVORED;
         n_fav_grants++;
      end else if (stv_tags.size() != 0) begin
         if (fav_tags.size() != 0) begin
            n_forced_stv++;
         end
         starve_cnt       = '0;
         rsp.status       = ST_GRANT;
         rsp.grant_tag    = stv_tags.pop_front();
         rsp.grant_class  = CLASS_STARVABLE;
         n_stv_grants++;
      end else begin
         if (fav_tags.size() != 0) begin
            n_starved_empty++;
         end
         starve_cnt = '0;
         rsp.status = ST_NONE;
         n_none++;
      end
      return rsp;
   endfunction

   always @(posedge clock) begin
      rsp_beat_type want;
      if (!reset && rsp_valid) begin
         if (awaited_rsp_q.size() == 0) begin
            report_mismatch("response beat with nothing awaited");
         end else begin
            want = awaited_rsp_q.pop_front();
            if (rsp_data.status !== want.status) begin
               report_mismatch($sformatf("status %0d, want %0d", rsp_data.status,
                                         want.status));
            end
            if (rsp_data.grant_tag !== want.grant_tag) begin
               report_mismatch($sformatf("grant_tag %h, want %h", rsp_data.grant_tag,
                                         want.grant_tag));
            end
            if (rsp_data.grant_class !== want.grant_class) begin
               report_mismatch($sformatf("grant_class %b, want %b", rsp_data.grant_class,
                                         want.grant_class));
            end
         end
      end
   end

   task automatic send_beat(input logic action, input logic [TAG_W-1:0] tag, input logic cls);
      req_beat_type beat;
      beat.action    = action;
      beat.req_tag   = tag;
      beat.req_class = cls;
      while (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start    <= 1'b1;
      req_data <= beat;
      do @(posedge clock); while (busy !== 1'b0);
      awaited_rsp_q.push_back(arbiter_response(beat));
   endtask

   task automatic write_limit(input logic [LIMIT_W-1:0] value);
      start <= 1'b0;
      while (awaited_rsp_q.size() != 0) @(posedge clock);
      csr_we    <= 1'b1;
      csr_wdata <= value;
      @(posedge clock);
      csr_we     <= 1'b0;
      starve_lim  = value;
   endtask

   task automatic test_reset_limit();
      send_beat(ACT_DISPATCH, 16'hFFFF, CLASS_STARVABLE);
      send_beat(ACT_ADD, 16'hFFFF, CLASS_STARVABLE);
      send_beat(ACT_ADD, 16'h0000, CLASS_FAVORED);
      send_beat(ACT_ADD, 16'hFFFF, CLASS_FAVORED);
      repeat (4) send_beat(ACT_ADD, 16'($urandom), CLASS_FAVORED);
      repeat (7) send_beat(ACT_DISPATCH, 16'($urandom), 1'($urandom));
   endtask

   task automatic test_starved_empty();
      write_limit(8'd0);
      repeat (2) send_beat(ACT_ADD, 16'($urandom), CLASS_FAVORED);
      repeat (3) send_beat(ACT_DISPATCH, 16'($urandom), CLASS_FAVORED);
   endtask

   // Keeps the favored queue fed so the counter climbs past the maximum limit of 255.
   task automatic test_starvation_extreme();
      write_limit(8'd255);
      repeat (2) send_beat(ACT_ADD, 16'($urandom), CLASS_STARVABLE);
      repeat (300) begin
         send_beat(ACT_ADD, 16'($urandom), CLASS_FAVORED);
         send_beat(ACT_DISPATCH, 16'($urandom), 1'($urandom));
      end
   endtask

   task automatic test_random_traffic(input logic [LIMIT_W-1:0] limit, input int count);
      int stv_pct;
      int add_pct;
      write_limit(limit);
      stv_pct = $urandom_range(70, 30);
      for (int i = 0; i < count; i++) begin
         add_pct = (i < count / 2) ? 80 : 35;
         send_beat(($urandom_range(99) < add_pct) ? ACT_ADD : ACT_DISPATCH,
                   16'($urandom),
                   ($urandom_range(99) < stv_pct) ? CLASS_STARVABLE : CLASS_FAVORED);
      end
   endtask

   initial begin
      reset      = 1'b1;
      start      = 1'b0;
      req_data   = '0;
      csr_we     = 1'b0;
      csr_wdata  = '0;
      starve_cnt = '0;
      starve_lim = STARVE_LIMIT_RESET;
      idle_pct   = 33;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      test_reset_limit();
      test_starved_empty();
      test_random_traffic(8'd0, 170);
      test_random_traffic(8'($urandom_range(255, 1)), 170);

      idle_pct = 77;
      test_starvation_extreme();
      test_random_traffic(8'd255, 170);
      test_random_traffic(8'd1, 170);

      idle_pct = 0;
      test_random_traffic(8'($urandom), 170);
      test_random_traffic(STARVE_LIMIT_RESET, 170);

      start <= 1'b0;
      while (awaited_rsp_q.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);

      $display("Sent %0d beats: %0d adds, %0d rejected on a full queue, %0d empty dispatches.",
               n_beats, n_added, n_full, n_none);
      $display("Grants: %0d favored, %0d starvable (%0d forced by the limit, %0d starved idle).",
               n_fav_grants, n_stv_grants, n_forced_stv, n_starved_empty);
      if (errors == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
